@@ sv/hsc_pkg.sv @@
package hsc_pkg;

  // Widths of the stream fields
  localparam int WORD_W = 63;
  localparam int SYN_W  = 6;
  localparam int DATA_W = 57;   // data bits of the longest code
  localparam int PCNT_W = 3;

  // Command codes carried on the input tuser
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Parity count limits and the code lengths they select
  localparam logic [PCNT_W-1:0] MIN_PARITY = 3'd3;
  localparam int LEN_7  = 7;
  localparam int LEN_15 = 15;
  localparam int LEN_31 = 31;
  localparam int LEN_63 = 63;

  // Positions whose index has bit bitpos set (position p is bit p-1)
  function automatic logic [WORD_W-1:0] cover_mask(int unsigned bitpos);
    logic [WORD_W-1:0] mask;
    mask = '0;
    for (int unsigned p = 1; p <= WORD_W; p++) begin
      mask[p-1] = ((p >> bitpos) & 1) != 0;
    end
    return mask;
  endfunction

  // Place data bits in ascending order at the non-power-of-two positions
  function automatic logic [WORD_W-1:0] scatter(logic [DATA_W-1:0] data);
    logic [WORD_W-1:0] word;
    int unsigned       k;
    word = '0;
    k    = 0;
    for (int unsigned p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        word[p-1] = data[k];
        k++;
      end
    end
    return word;
  endfunction

  // Collect the non-power-of-two positions back into a data word
  function automatic logic [DATA_W-1:0] gather(logic [WORD_W-1:0] word);
    logic [DATA_W-1:0] data;
    int unsigned       k;
    data = '0;
    k    = 0;
    for (int unsigned p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        data[k] = word[p-1];
        k++;
      end
    end
    return data;
  endfunction

endpackage

@@ sv/hsc_syndrome.sv @@
module hsc_syndrome (
  input  logic [hsc_pkg::WORD_W-1:0] word,
  output logic [hsc_pkg::SYN_W-1:0]  syn
);
  import hsc_pkg::*;

  // One XOR tree per syndrome bit over the positions it covers
  for (genvar i = 0; i < SYN_W; i++) begin : g_syn
    localparam logic [WORD_W-1:0] COVER = cover_mask(i);
    assign syn[i] = ^(word & COVER);
  end

endmodule

@@ sv/hamming_sec_codec.sv @@
// Hamming single-error-correcting codec for the (7,4), (15,11), (31,26) and
// (63,57) codes, chosen by the parity count written on cfg_wr_data (values
// below 3 act as 3, values above MAX_PARITY as MAX_PARITY). Write it only
// while no beat is in flight. Each input beat carries the command on tuser
// (0 encode, 1 decode) and a low-aligned word on tdata; each produces one
// output beat. The block takes one beat per clock while the output is ready,
// through its three register stages: word masking and data placement,
// the syndrome XOR trees, and parity insertion or correction with data
// extraction. Backpressure stalls the stages in place without loss.
module hamming_sec_codec #(
  parameter int MAX_PARITY = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [hsc_pkg::PCNT_W-1:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [62:0] data_word, [63] zero fill
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [62:0] result_word, [68:63] syndrome,
                                      // [69] corrected, [71:70] zero fill
);
  import hsc_pkg::*;

  localparam logic [PCNT_W-1:0] MAX_M = PCNT_W'(MAX_PARITY);

  logic [PCNT_W-1:0] parity_count;

  // Hold the saturated parity count
  always_ff @(posedge clk) begin
    if (rst) begin
      parity_count <= MIN_PARITY;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < MIN_PARITY) begin
        parity_count <= MIN_PARITY;
      end else if (cfg_wr_data > MAX_M) begin
        parity_count <= MAX_M;
      end else begin
        parity_count <= cfg_wr_data;
      end
    end
  end

  // Codeword and data masks for the selected code
  logic [WORD_W-1:0] n_mask;
  logic [DATA_W-1:0] k_mask;

  always_comb begin
    case (parity_count)
      3'd3: begin
        n_mask = ~({WORD_W{1'b1}} << LEN_7);
        k_mask = ~({DATA_W{1'b1}} << (LEN_7 - 3));
      end
      3'd4: begin
        n_mask = ~({WORD_W{1'b1}} << LEN_15);
        k_mask = ~({DATA_W{1'b1}} << (LEN_15 - 4));
      end
      3'd5: begin
        n_mask = ~({WORD_W{1'b1}} << LEN_31);
        k_mask = ~({DATA_W{1'b1}} << (LEN_31 - 5));
      end
      default: begin
        n_mask = ~({WORD_W{1'b1}} << LEN_63);
        k_mask = ~({DATA_W{1'b1}} << (LEN_63 - 6));
      end
    endcase
  end

  // Stage handshake: a stage loads when it is empty or draining
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3          = !v3 || m_axis_tready;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v3;

  // Stage 1: mask the word and place data bits for encode
  logic              cmd1;
  logic [WORD_W-1:0] word1;
  logic [WORD_W-1:0] in_word;

  assign in_word = s_axis_tdata[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_axis_tvalid) begin
      cmd1 <= s_axis_tuser;
      if (s_axis_tuser == CMD_ENCODE) begin
        word1 <= scatter(in_word[DATA_W-1:0] & k_mask);
      end else begin
        word1 <= in_word & n_mask;
      end
    end
  end

  // Stage 2: syndrome over the placed word
  logic              cmd2;
  logic [WORD_W-1:0] word2;
  logic [SYN_W-1:0]  syn2;
  logic [SYN_W-1:0]  syn_calc;

  hsc_syndrome u_syndrome (
    .word (word1),
    .syn  (syn_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      cmd2  <= cmd1;
      word2 <= word1;
      syn2  <= syn_calc;
    end
  end

  // Stage 3: insert parity on encode, flip the named bit and extract on decode
  logic [WORD_W-1:0] chk_word;
  logic [WORD_W-1:0] flip_bit;
  logic [WORD_W-1:0] fixed_word;
  logic [WORD_W-1:0] result_next;
  logic [SYN_W-1:0]  syn_next;
  logic              corr_next;

  always_comb begin
    chk_word = '0;
    for (int i = 0; i < SYN_W; i++) begin
      chk_word[(1 << i) - 1] = syn2[i];
    end
  end

  always_comb begin
    flip_bit = '0;
    if (syn2 != '0) begin
      flip_bit = {{(WORD_W-1){1'b0}}, 1'b1} << (syn2 - SYN_W'(1));
    end
  end

  assign fixed_word = word2 ^ flip_bit;

  always_comb begin
    if (cmd2 == CMD_ENCODE) begin
      result_next = word2 | chk_word;
      syn_next    = '0;
      corr_next   = 1'b0;
    end else begin
      result_next = {{(WORD_W-DATA_W){1'b0}}, gather(fixed_word)};
      syn_next    = syn2;
      corr_next   = syn2 != '0;
    end
  end

  logic [WORD_W-1:0] result_word;
  logic [SYN_W-1:0]  syndrome;
  logic              corrected;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      result_word <= result_next;
      syndrome    <= syn_next;
      corrected   <= corr_next;
    end
  end

  assign m_axis_tdata = {2'b00, corrected, syndrome, result_word};

`ifndef SYNTHESIS
  // A stalled first stage keeps its beat
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(word1) && $stable(cmd1)))
    else $error("stage 1 beat changed while stalled");

  // A stalled second stage keeps its beat and syndrome
  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !rdy3) |=> (v2 && $stable(word2) && $stable(syn2)))
    else $error("stage 2 beat changed while stalled");

  // An encode beat leaves with clear decode status
  a_encode_status: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3 && cmd2 == CMD_ENCODE) |=>
      (m_axis_tvalid && syndrome == '0 && !corrected))
    else $error("encode beat carries decode status");
`endif

endmodule
